// ----- design/lct_pkg.sv -----
// Shared types and constants for the LFU cache table.
// Used by lct_ctrl, lct_datapath and lfu_cache_table_core; depends on nothing.
package lct_pkg;

  // Widths fixed by the request and result fields.
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned STAMP_W = 32;

  // Default table depth and register reset value.
  localparam int unsigned          DEFAULT_ENTRIES = 16;
  localparam logic [CAP_W-1:0]     CAP_RESET       = 5'd16;

  // Use count saturates here; a get miss returns all ones.
  localparam logic [COUNT_W-1:0]   COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0]   COUNT_ONE  = 16'd1;
  localparam logic [DATA_W-1:0]    MISS_VALUE = '1;

  // Request opcodes.
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  // One stored slot: everything except the valid bit.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  value;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } dp_status_t;

endpackage

// ----- design/lfu_cache_table_core.sv -----
// Top level of the LFU cache table: key/value store with least-frequently-used
// replacement, ties broken by least recent use. Depends on lct_pkg, lct_ctrl, lct_datapath.
//
// Usage:
//   A request (opcode_i, key_i, data_in_i) is taken at a rising edge where
//   start_i is high and busy_o is low. busy_o then stays high until the
//   request finishes. opcode 0 is a get, 1 is a put.
//   Each request yields one result (hit_o, data_out_o, evicted_o), shown for
//   exactly one cycle with done_o high. The receiver cannot stall; the result
//   is gone after that cycle.
//   A request passes through the scan, drain and commit states before done_o is
//   seen. busy_o drops as done_o rises, so a new request is accepted only after
//   the last one has finished. The serial scan sets this pace: the slot memory has
//   one read port and delivers one slot per cycle for the key match, free slot and
//   victim search. Capacity is written on cfg_valid_i/cfg_data_i (always ready)
//   while idle, a rule on the user that the block does not enforce. Reset empties
//   the table, clears the use clock and sets capacity to 16; no clearing pass is
//   needed, so requests are taken right after reset.
module lfu_cache_table_core
  import lct_pkg::*;
#(
  parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     opcode_i,
  input  logic signed [KEY_W-1:0]  key_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  output logic                     done_o,
  output logic                     hit_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic                     evicted_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CAP_W-1:0]         cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // The capacity register can always take a write.
  assign cfg_ready_o = 1'b1;

  lct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .st_i    (st),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  lct_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .opcode_i    (opcode_i),
    .key_i       (key_i),
    .data_in_i   (data_in_i),
    .done_o      (done_o),
    .hit_o       (hit_o),
    .data_out_o  (data_out_o),
    .evicted_o   (evicted_o)
  );

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("block not busy after accepting a request");

  // Results are single-cycle strobes, never back to back.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A result appears only as the block leaves its busy phase.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o))
    else $error("result strobe outside the end of a request");

endmodule

// ----- design/lct_ctrl.sv -----
// Request sequencer for the LFU cache table.
// Depends on lct_pkg for the state enum and the command and status structs.
module lct_ctrl
  import lct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t st_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: capture, scan every slot, let the last read settle, then commit.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (st_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs decoded from the current state; in idle, capture also follows start_i.
  always_comb begin
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o = '0;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

// ----- design/lct_datapath.sv -----
// Slot storage, serial scan trackers, update logic and result registers.
// Depends on lct_pkg; driven by lct_ctrl through ctrl_cmd_t.
module lct_datapath
  import lct_pkg::*;
#(
  parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_cmd_t                cmd_i,
  output dp_status_t               st_o,
  input  logic                     cfg_valid_i,
  input  logic [CAP_W-1:0]         cfg_data_i,
  input  logic                     opcode_i,
  input  logic signed [KEY_W-1:0]  key_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  output logic                     done_o,
  output logic                     hit_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic                     evicted_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Control state.
  logic [CAP_W-1:0]   cap_q;
  logic [OCC_W-1:0]   occ_q;
  logic [STAMP_W-1:0] clock_q;
  logic [ENTRIES-1:0] valid_q;
  logic               rd_vld_q;
  logic               done_q;
  logic               match_found_q, free_found_q, vic_found_q;

  // Payload registers.
  entry_t             mem_q [ENTRIES];
  entry_t             rd_word_q;
  logic               rd_valid_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [IDX_W-1:0]   scan_q;
  op_e                req_op_q;
  logic [KEY_W-1:0]   req_key_q;
  logic [DATA_W-1:0]  req_data_q;
  logic [IDX_W-1:0]   match_idx_q, free_idx_q, vic_idx_q;
  logic [DATA_W-1:0]  match_val_q;
  logic [COUNT_W-1:0] match_cnt_q, vic_cnt_q;
  logic [STAMP_W-1:0] vic_stamp_q;
  logic               hit_q, ev_q;
  logic [DATA_W-1:0]  dout_q;

  // Scan comparisons and commit decisions.
  logic               is_match, is_free, is_better;
  logic [CMP_W-1:0]   cap_ext, cap_eff, occ_ext;
  logic [COUNT_W-1:0] cnt_inc;
  logic               wr_en, occ_inc, res_hit, res_ev;
  logic [IDX_W-1:0]   wr_idx;
  entry_t             wr_word;
  logic [DATA_W-1:0]  res_dout;

  assign st_o.scan_last = (scan_q == IDX_W'(ENTRIES - 1));

  // The effective capacity is the capacity register clamped to the table depth.
  assign cap_ext = CMP_W'(cap_q);
  assign cap_eff = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign occ_ext = CMP_W'(occ_q);

  // Per-slot tests on the word read in the previous cycle.
  assign is_match  = rd_vld_q && rd_valid_q && (rd_word_q.key == req_key_q) && !match_found_q;
  assign is_free   = rd_vld_q && !rd_valid_q && !free_found_q;
  assign is_better = rd_vld_q && rd_valid_q &&
                     (!vic_found_q || (rd_word_q.count < vic_cnt_q) ||
                      ((rd_word_q.count == vic_cnt_q) && (rd_word_q.stamp < vic_stamp_q)));

  assign cnt_inc = (match_cnt_q == COUNT_MAX) ? match_cnt_q : COUNT_W'(match_cnt_q + COUNT_ONE);

  // Commit: decide the slot write and the result from the scan trackers.
  always_comb begin
    res_hit       = match_found_q;
    res_dout      = '0;
    res_ev        = 1'b0;
    wr_en         = 1'b0;
    occ_inc       = 1'b0;
    wr_idx        = match_idx_q;
    wr_word.key   = req_key_q;
    wr_word.value = req_data_q;
    wr_word.count = cnt_inc;
    wr_word.stamp = clock_q;
    if (req_op_q == OP_GET) begin
      if (match_found_q) begin
        res_dout      = match_val_q;
        wr_word.value = match_val_q;
        wr_en         = 1'b1;
      end else begin
        res_dout = MISS_VALUE;
      end
    end else if (cap_eff != '0) begin
      if (match_found_q) begin
        wr_en = 1'b1;
      end else if (occ_ext < cap_eff) begin
        wr_word.count = COUNT_ONE;
        wr_idx        = free_idx_q;
        wr_en         = free_found_q;
        occ_inc       = free_found_q;
      end else begin
        wr_word.count = COUNT_ONE;
        wr_idx        = vic_idx_q;
        wr_en         = vic_found_q;
        res_ev        = vic_found_q;
      end
    end
  end

  // Control registers: capacity, occupancy, use clock, valid bits, strobes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q         <= CAP_RESET;
      occ_q         <= '0;
      clock_q       <= '0;
      valid_q       <= '0;
      rd_vld_q      <= 1'b0;
      done_q        <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      vic_found_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) cap_q <= cfg_data_i;
      rd_vld_q <= cmd_i.scan_rd;
      done_q   <= cmd_i.commit;
      if (cmd_i.capture) begin
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
        vic_found_q   <= 1'b0;
      end else begin
        if (is_match)  match_found_q <= 1'b1;
        if (is_free)   free_found_q  <= 1'b1;
        if (is_better) vic_found_q   <= 1'b1;
      end
      if (cmd_i.commit && wr_en) begin
        valid_q[wr_idx] <= 1'b1;
        clock_q         <= clock_q + 1'b1;
        if (occ_inc) occ_q <= occ_q + 1'b1;
      end
    end
  end

  // Request capture, scan pointer and tracker payloads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_op_q   <= op_e'(opcode_i);
      req_key_q  <= key_i;
      req_data_q <= data_in_i;
      scan_q     <= '0;
    end else if (cmd_i.scan_rd && !st_o.scan_last) begin
      scan_q <= scan_q + 1'b1;
    end
    if (is_match) begin
      match_idx_q <= rd_idx_q;
      match_val_q <= rd_word_q.value;
      match_cnt_q <= rd_word_q.count;
    end
    if (is_free) free_idx_q <= rd_idx_q;
    if (is_better) begin
      vic_idx_q   <= rd_idx_q;
      vic_cnt_q   <= rd_word_q.count;
      vic_stamp_q <= rd_word_q.stamp;
    end
    if (cmd_i.commit) begin
      hit_q  <= res_hit;
      dout_q <= res_dout;
      ev_q   <= res_ev;
    end
  end

  // Slot memory: one registered read during the scan, one write at commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_word_q  <= mem_q[scan_q];
      rd_valid_q <= valid_q[scan_q];
      rd_idx_q   <= scan_q;
    end
    if (cmd_i.commit && wr_en) begin
      mem_q[wr_idx] <= wr_word;
    end
  end

  assign done_o     = done_q;
  assign hit_o      = hit_q;
  assign data_out_o = dout_q;
  assign evicted_o  = ev_q;

  // The fill count always matches the number of occupied slots.
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == OCC_W'($countones(valid_q)))
    else $error("occupancy count differs from the number of valid slots");

  // An eviction is only reported for a put of a key that was absent.
  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && ev_q |-> !hit_q && (req_op_q == OP_PUT))
    else $error("eviction reported on a hit or on a get");

  // A commit that writes a slot always advances the use clock.
  a_clock_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && wr_en |=> clock_q == $past(clock_q) + 1'b1)
    else $error("use clock did not advance on a slot write");

endmodule

// ----- verif/lfu_cache_table_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for lfu_cache_table_core: a shadow LFU table predicts every reply.
// Depends on lct_pkg and the lfu_cache_table_core RTL; needs no files or arguments.
module lfu_cache_table_core_test;
  import lct_pkg::*;

  localparam int unsigned TABLE_DEPTH  = DEFAULT_ENTRIES;
  localparam int unsigned POOL_SIZE    = 20;
  localparam int unsigned DRAIN_LIMIT  = 2000;

  // One reply of the block: the fields that arrive with done_o.
  typedef struct {
    logic              hit;
    logic [DATA_W-1:0] data;
    logic              evicted;
  } cache_reply_t;

  // Shadow copy of the table; predicts the reply of each accepted request
  // and compares the block's replies against them in order.
  class lfu_shadow_table;
    logic [CAP_W-1:0]   capacity;
    bit                 slot_used  [TABLE_DEPTH];
    logic [KEY_W-1:0]   slot_key   [TABLE_DEPTH];
    logic [DATA_W-1:0]  slot_value [TABLE_DEPTH];
    logic [COUNT_W-1:0] slot_count [TABLE_DEPTH];
    logic [STAMP_W-1:0] slot_stamp [TABLE_DEPTH];
    int unsigned        occupied;
    logic [STAMP_W-1:0] use_clock;
    cache_reply_t       replies_due[$];
    int unsigned        error_count;

    function new();
      capacity    = CAP_RESET;
      occupied    = 0;
      use_clock   = '0;
      error_count = 0;
      foreach (slot_used[i]) begin
        slot_used[i]  = 1'b0;
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_count[i] = '0;
        slot_stamp[i] = '0;
      end
    endfunction

    // Every hit and every insertion takes the next value of the use clock.
    function void stamp_slot(int unsigned s);
      slot_stamp[s] = use_clock;
      use_clock     = use_clock + 1;
    endfunction

    // A hit raises the use count, which stops at its maximum.
    function void touch_slot(int unsigned s);
      if (slot_count[s] != COUNT_MAX) slot_count[s] = slot_count[s] + 1;
      stamp_slot(s);
    endfunction

    function void note_request(op_e op, logic [KEY_W-1:0] key, logic [DATA_W-1:0] val);
      int unsigned  i, eff_cap, found, target;
      cache_reply_t r;
      eff_cap = (capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity;
      found   = TABLE_DEPTH;
      for (i = 0; i < TABLE_DEPTH; i++)
        if (found == TABLE_DEPTH && slot_used[i] && slot_key[i] == key) found = i;
      r.hit     = (found < TABLE_DEPTH);
      r.data    = '0;
      r.evicted = 1'b0;
      if (op == OP_GET) begin
        if (r.hit) begin
          r.data = slot_value[found];
          touch_slot(found);
        end else begin
          r.data = MISS_VALUE;
        end
      end else if (eff_cap != 0) begin
        if (r.hit) begin
          slot_value[found] = val;
          touch_slot(found);
        end else begin
          target = TABLE_DEPTH;
          if (occupied < eff_cap) begin
            // Room left: take the lowest free slot.
            for (i = 0; i < TABLE_DEPTH; i++)
              if (target == TABLE_DEPTH && !slot_used[i]) target = i;
            if (target < TABLE_DEPTH) occupied++;
          end else begin
            // Full: lowest count goes, the oldest stamp among equal counts.
            for (i = 0; i < TABLE_DEPTH; i++)
              if (slot_used[i] && (target == TABLE_DEPTH ||
                  slot_count[i] < slot_count[target] ||
                  (slot_count[i] == slot_count[target] &&
                   slot_stamp[i] < slot_stamp[target])))
                target = i;
            if (target < TABLE_DEPTH) r.evicted = 1'b1;
          end
          if (target < TABLE_DEPTH) begin
            slot_used[target]  = 1'b1;
            slot_key[target]   = key;
            slot_value[target] = val;
            slot_count[target] = COUNT_ONE;
            stamp_slot(target);
          end
        end
      end
      replies_due.push_back(r);
    endfunction

    // Every mismatch is counted and reported.
    function void flag_mismatch(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_reply(logic hit, logic [DATA_W-1:0] data, logic evicted);
      cache_reply_t want;
      if (replies_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected reply, expected none, actual hit=%b data_out=%h evicted=%b",
                 $time, hit, data, evicted);
        return;
      end
      want = replies_due.pop_front();
      if (hit !== want.hit)         flag_mismatch("hit", want.hit, hit);
      if (data !== want.data)       flag_mismatch("data_out", want.data, data);
      if (evicted !== want.evicted) flag_mismatch("evicted", want.evicted, evicted);
    endfunction
  endclass

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     start_i     = 1'b0;
  logic                     busy_o;
  logic                     opcode_i    = OP_GET;
  logic signed [KEY_W-1:0]  key_i       = '0;
  logic signed [DATA_W-1:0] data_in_i   = '0;
  logic                     done_o;
  logic                     hit_o;
  logic signed [DATA_W-1:0] data_out_o;
  logic                     evicted_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CAP_W-1:0]         cfg_data_i  = '0;

  lfu_shadow_table  shadow = new();
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  lfu_cache_table_core #(
    .ENTRIES (TABLE_DEPTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .opcode_i    (opcode_i),
    .key_i       (key_i),
    .data_in_i   (data_in_i),
    .done_o      (done_o),
    .hit_o       (hit_o),
    .data_out_o  (data_out_o),
    .evicted_o   (evicted_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Replies last one cycle and cannot be held off, so sample every edge.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) shadow.check_reply(hit_o, data_out_o, evicted_o);
  end

  // Holds a request on the ports until the block takes it.
  task automatic send_request(op_e op, logic [KEY_W-1:0] key, logic [DATA_W-1:0] val);
    start_i   <= 1'b1;
    opcode_i  <= op;
    key_i     <= key;
    data_in_i <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    shadow.note_request(op, key, val);
  endtask

  // Random gap on the request side; pct is the idle chance per cycle.
  task automatic sender_pause(int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < pct) @(posedge clk_i);
    end
  endtask

  // Every request gives a reply, so an empty queue means the block is idle.
  task automatic wait_quiet();
    start_i <= 1'b0;
    while (shadow.replies_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_quiet();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    shadow.capacity = cap;
  endtask

  // Mostly keys from a small pool, so hits, updates and evictions are common.
  task automatic random_requests(int unsigned count, int unsigned pct);
    int unsigned      n;
    op_e              op;
    logic [KEY_W-1:0] key;
    for (n = 0; n < count; n++) begin
      op  = ($urandom_range(1) == 1) ? OP_PUT : OP_GET;
      key = ($urandom_range(9) < 7) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
      send_request(op, key, $urandom);
      sender_pause(pct);
    end
  endtask

  initial begin
    int unsigned      phase, seg, drain_cycles;
    int unsigned      idle_pct [3];
    logic [CAP_W-1:0] extreme_cap [4];
    idle_pct    = '{22, 86, 0};
    extreme_cap = '{5'd16, 5'd0, 5'd1, 5'd31};
    foreach (key_pool[i]) key_pool[i] = $urandom;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes at reset capacity, including a stored value equal to the miss value.
    send_request(OP_GET, 32'h0000_0000, $urandom);
    send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'h8000_0000, 32'h1234_5678);
    send_request(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);

    // Capacity below the occupancy: new keys replace victims, ties go by recency.
    write_capacity(5'd2);
    send_request(OP_PUT, 32'h0000_0005, 32'h0000_0055);
    send_request(OP_PUT, 32'h0000_0006, 32'h0000_0066);
    send_request(OP_GET, 32'h0000_0006, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_0007, 32'h0000_0077);

    // Zero capacity: puts change nothing but still report presence.
    write_capacity(5'd0);
    send_request(OP_PUT, 32'h0000_0009, 32'h0000_0099);
    send_request(OP_PUT, 32'h0000_0006, 32'hDEAD_BEEF);
    send_request(OP_GET, 32'h0000_0009, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0006, 32'h0000_0000);

    // Capacity above the table depth saturates to the depth.
    write_capacity(5'd31);
    send_request(OP_PUT, 32'h0000_000A, 32'h0000_00AA);
    send_request(OP_PUT, 32'h0000_000B, 32'h0000_00BB);
    send_request(OP_GET, 32'h0000_000A, 32'h0000_0000);

    // Random traffic: three request-side idle rates, four capacity settings each.
    for (phase = 0; phase < 3; phase++) begin
      for (seg = 0; seg < 4; seg++) begin
        write_capacity((phase == 0) ? extreme_cap[seg] : CAP_W'($urandom_range(31)));
        random_requests(40, idle_pct[phase]);
      end
    end

    // Drain the outstanding replies, then give the block time for strays.
    start_i <= 1'b0;
    drain_cycles = 0;
    while (shadow.replies_due.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (TABLE_DEPTH + 4) @(posedge clk_i);
    if (shadow.replies_due.size() != 0) begin
      shadow.error_count++;
      $display("%0t: missing replies, expected %0d more, actual 0",
               $time, shadow.replies_due.size());
    end
    if (shadow.error_count == 0) begin
      $display("PASS lfu_cache_table_core");
    end else begin
      $display("FAIL lfu_cache_table_core");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #1_000_000;
    $display("FAIL lfu_cache_table_core");
    $finish;
  end

endmodule
